// ===== src/transpose_search_list_macros.svh =====
// Assertion macros used by the search list engine (tsl_back)
`ifndef TRANSPOSE_SEARCH_LIST_MACROS_SVH
`define TRANSPOSE_SEARCH_LIST_MACROS_SVH

`ifndef SYNTH
`define TSL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TSL_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TSL_ASSERT(lbl, clk, rst, prop, msg)
`define TSL_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== src/tsl_pkg.sv =====
// Types and constants shared by the search list modules
package tsl_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned POS_W         = 5;

  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

// ===== src/tsl_front.sv =====
// Input queue: accepts words, decodes the operation, holds them for the engine
module tsl_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               kind,
  input  logic signed [tsl_pkg::VALUE_W-1:0] value,
  input  logic                               cmd_pop,
  output logic                               cmd_empty,
  output tsl_pkg::cmd_t                      cmd
);
  import tsl_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;
  cmd_t       decoded;

  always_comb begin
    decoded.op    = (kind == KIND_SEARCH) ? OP_SEARCH : OP_INSERT;
    decoded.value = value;
  end

  assign full      = (fill == 2'd2);
  assign cmd_empty = (fill == 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && !cmd_empty;
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= decoded;
  end

endmodule

// ===== src/tsl_res_queue.sv =====
// Result queue: holds finished words until the consumer pops them
module tsl_res_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         res_push,
  input  tsl_pkg::res_t                res,
  output logic                         res_full,
  input  logic                         pop,
  output logic                         empty,
  output logic [tsl_pkg::STATUS_W-1:0] status,
  output logic [tsl_pkg::POS_W-1:0]    position
);
  import tsl_pkg::*;

  res_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign res_full = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign status   = slot[rd_ptr].status;
  assign position = slot[rd_ptr].position;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= res;
  end

endmodule

// ===== src/tsl_back.sv =====
// List engine: entry memory, sequential scan and transpose swap
`include "transpose_search_list_macros.svh"

module tsl_back #(
  parameter int unsigned DEPTH = tsl_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  tsl_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output tsl_pkg::res_t res
);
  import tsl_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (AW + 1 > POS_W) ? AW + 1 : POS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SWAP = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] key;
  logic [VALUE_W-1:0] prev_data;
  logic [CW-1:0]      count;
  logic [CW-1:0]      issue_idx;
  logic [AW-1:0]      cmp_idx;
  logic [AW-1:0]      rd_addr;
  logic               rd_vld;
  logic               issuing;
  logic               match;
  logic               last;
  logic               start_search;
  logic               count_inc;
  logic               we;
  logic [AW-1:0]      wa;
  logic [VALUE_W-1:0] wd;
  logic [PW-1:0]      pos_wide;

  assign match    = rd_vld && (rd_data == key);
  assign last     = ((CW'(cmp_idx) + CW'(1)) == count);
  assign issuing  = (state == S_SCAN) && (issue_idx < count) && !match;
  assign rd_addr  = issue_idx[AW-1:0];
  assign pos_wide = PW'(cmp_idx) + PW'(1);

  always_comb begin
    state_next   = state;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res.status   = ST_OK;
    res.position = '0;
    we           = 1'b0;
    wa           = '0;
    wd           = '0;
    start_search = 1'b0;
    count_inc    = 1'b0;
    case (state)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_INSERT) begin
            res_push = 1'b1;
            if (count == CW'(DEPTH)) begin
              res.status = ST_FULL;
            end else begin
              we        = 1'b1;
              wa        = count[AW-1:0];
              wd        = cmd.value;
              count_inc = 1'b1;
            end
          end else if (count == '0) begin
            res_push   = 1'b1;
            res.status = ST_NOT_FOUND;
          end else begin
            start_search = 1'b1;
            state_next   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          res_push     = 1'b1;
          res.position = pos_wide[POS_W-1:0];
          if (cmp_idx != '0) begin
            we         = 1'b1;
            wa         = cmp_idx;
            wd         = prev_data;
            state_next = S_SWAP;
          end else begin
            state_next = S_IDLE;
          end
        end else if (rd_vld && last) begin
          res_push   = 1'b1;
          res.status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_SWAP: begin
        we         = 1'b1;
        wa         = cmp_idx - AW'(1);
        wd         = key;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
      issue_idx <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= issuing;
      if (count_inc) count <= count + CW'(1);
      if (start_search) begin
        issue_idx <= '0;
      end else if (issuing) begin
        issue_idx <= issue_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
    if (start_search) key <= cmd.value;
    if (issuing) cmp_idx <= rd_addr;
    if (rd_vld && !match) prev_data <= rd_data;
  end

  `TSL_ASSERT(a_count_max, clk, rst, count <= CW'(DEPTH), "entry count above depth")
  `TSL_ASSERT_NEVER(a_push_full, clk, rst, res_push && res_full, "result pushed into full queue")
  `TSL_ASSERT(a_scan_nonempty, clk, rst, (state == S_SCAN) |-> (count != '0), "scan of empty list")
  `TSL_ASSERT(a_hit_swap, clk, rst, (state == S_SCAN && match && cmp_idx != '0) |=> (state == S_SWAP), "hit without swap")
  `TSL_ASSERT(a_count_busy, clk, rst, (state != S_IDLE) |=> $stable(count), "count moved mid search")

endmodule

// ===== src/transpose_search_list.sv =====
// Top level: self-organising search list with transpose on hit
//
// Keeps up to DEPTH 32-bit words in list order. Insert words append at the tail.
// Search words scan from the head, one entry per cycle through the single read
// port of the entry memory: a hit at position k > 1 then writes back the swap
// with the predecessor in a separate swap state; a miss scans every entry, and
// a search of an empty list reports not found without a scan.
// Two-deep queues on input and result sides let a producer and a consumer
// stall independently of the engine.
module transpose_search_list #(
  parameter int unsigned DEPTH = tsl_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               kind,
  input  logic signed [tsl_pkg::VALUE_W-1:0] value,
  output logic                               empty,
  input  logic                               pop,
  output logic [tsl_pkg::STATUS_W-1:0]       status,
  output logic [tsl_pkg::POS_W-1:0]          position
);
  import tsl_pkg::*;

  cmd_t cmd;
  logic cmd_pop;
  logic cmd_empty;
  res_t res;
  logic res_push;
  logic res_full;

  tsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .value     (value),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  tsl_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  tsl_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .status   (status),
    .position (position)
  );

endmodule

// ===== sim/transpose_search_list_tb.sv =====
// Self-checking testbench for the transpose search list: directed and random words
`timescale 1ns / 100ps

module transpose_search_list_tb;
  import tsl_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_WORDS = 625;

  class search_list_tracker;
    logic signed [VALUE_W-1:0] entries [DEPTH_DEFAULT];
    int unsigned count;
    res_t pending[$];
    int errors;
    int inserts;
    int refused;
    int hits;
    int swaps;
    int misses;
    int results;

    function void note_command(op_t op, logic signed [VALUE_W-1:0] key);
      res_t r;
      logic signed [VALUE_W-1:0] held;
      bit found;
      int unsigned idx;
      r.status = ST_OK;
      r.position = '0;
      found = 1'b0;
      idx = 0;
      if (op == OP_INSERT) begin
        if (count >= DEPTH_DEFAULT) begin
          r.status = ST_FULL;
          refused++;
        end else begin
          entries[count] = key;
          count++;
          inserts++;
        end
      end else begin
        for (int i = 0; i < count; i++) begin
          if (!found && entries[i] == key) begin
            found = 1'b1;
            idx = i;
          end
        end
        if (found) begin
          r.position = POS_W'(idx + 1);
          hits++;
          if (idx > 0) begin
            held = entries[idx - 1];
            entries[idx - 1] = entries[idx];
            entries[idx] = held;
            swaps++;
          end
        end else begin
          r.status = ST_NOT_FOUND;
          misses++;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos);
      res_t exp_res;
      results++;
      if (pending.size() == 0) begin
        $error("unexpected result word: status %0d position %0d", st, pos);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (st !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, st);
        errors++;
      end
      if (pos !== exp_res.position) begin
        $error("position: expected %0d, got %0d", exp_res.position, pos);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic kind;
  logic signed [VALUE_W-1:0] value;
  logic empty;
  logic pop;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0] position;

  search_list_tracker sb = new;
  int send_burst;
  int drain_burst;
  int unsigned quiet;

  transpose_search_list dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .kind     (kind),
    .value    (value),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .position (position)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 30);
    return $urandom_range(0, 5);
  endfunction

  task automatic send_word(input op_t op, input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= op;
    value <= v;
    do @(posedge clk); while (full);
    sb.note_command(op, v);
  endtask

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("[transpose_search_list] ERROR");
      $finish;
    end
  end

  initial begin : drain
    int stall;
    bit held_off;
    held_off = 1'b0;
    pop = 1'b0;
    drain_burst = 0;
    wait (rst == 1'b0);
    forever begin
      stall = draw_gap(drain_burst);
      if (!held_off && sb.results == 200) begin
        stall = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(status, position);
    end
  end

  initial begin : stimulus
    int draw;
    logic signed [VALUE_W-1:0] key;
    rst = 1'b1;
    push = 1'b0;
    kind = OP_INSERT;
    value = '0;
    send_burst = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_SEARCH, 32'sd5);
    send_word(OP_INSERT, 32'sh8000_0000);
    send_word(OP_SEARCH, 32'sd0);
    send_word(OP_SEARCH, 32'sh8000_0000);
    send_word(OP_INSERT, 32'sh7FFF_FFFF);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_INSERT, 32'sh7FFF_FFFF);
    send_word(OP_SEARCH, -32'sd1);
    send_word(OP_SEARCH, -32'sd1);
    send_word(OP_SEARCH, 32'sh7FFF_FFFF);
    send_word(OP_SEARCH, 32'sh1234_5678);
    while (sb.count < DEPTH_DEFAULT) send_word(OP_INSERT, $urandom());
    send_word(OP_INSERT, 32'sh5555_AAAA);
    send_word(OP_SEARCH, sb.entries[DEPTH_DEFAULT-1]);
    send_word(OP_SEARCH, 32'shA5A5_5A5A);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      draw = $urandom_range(0, 99);
      key = sb.entries[$urandom_range(0, sb.count - 1)];
      if (draw < 15) begin
        send_word(OP_INSERT, $urandom());
      end else if (draw < 80) begin
        send_word(OP_SEARCH, key);
      end else if (draw < 90) begin
        send_word(OP_SEARCH, key ^ (32'sd1 << $urandom_range(0, VALUE_W - 1)));
      end else begin
        send_word(OP_SEARCH, $urandom());
      end
    end
    push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d inserts, %0d refused on a full list, %0d results checked",
             sb.inserts, sb.refused, sb.results);
    $display("searches: %0d hits, %0d of them moved forward, %0d misses",
             sb.hits, sb.swaps, sb.misses);
    if (sb.errors == 0) begin
      $display("[transpose_search_list] OK");
    end else begin
      $display("[transpose_search_list] ERROR");
    end
    $finish;
  end

endmodule
